// File: hw/rtl/shlne_pkg.sv
package shlne_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_STEP_DEF  = 16;

  localparam int NBANK      = 3;
  localparam int NTERM      = 9;
  localparam int BANK_DEPTH = NTERM + NTERM * NTERM;
  localparam int ENT_W      = $clog2(BANK_DEPTH);
  localparam int QDEPTH     = 2;
  localparam int VAL_W      = 64;
  localparam int TERM_W     = 48;
  localparam int SETUP_CYC  = 4;
  localparam int NADD       = 6;

  localparam int NUM_VEC    = NTERM * NBANK;
  localparam int NUM_SUMS   = NUM_VEC + NTERM * NTERM * NBANK;

  // sh basis constants in q.15
  localparam logic signed [16:0] K_C4  = 17'sd29040;
  localparam logic signed [16:0] K_2C2 = 17'sd33532;
  localparam logic signed [15:0] K_2C1 = 16'sd28118;
  localparam logic signed [15:0] K_C1  = 16'sd14059;
  localparam logic signed [15:0] K_C3  = 16'sd24351;
  localparam logic signed [16:0] K_C5  = 17'sd8117;

  localparam logic [0:0]  RST_PER_CHANNEL   = 1'b1;
  localparam logic [14:0] RST_MIRROR_WEIGHT = 15'd6554;
  localparam logic [4:0]  RST_SAMPLE_STEP   = 5'd1;
  localparam logic [12:0] RST_IMAGE_WIDTH   = 13'd640;

  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_ACC,
    CMD_READ,
    CMD_BAD,
    CMD_CLEAR
  } cmd_kind_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SETUP,
    BK_SWEEP,
    BK_READ
  } bk_state_t;

  typedef enum logic [1:0] {
    REG_PER_CHANNEL   = 2'd0,
    REG_MIRROR_WEIGHT = 2'd1,
    REG_SAMPLE_STEP   = 2'd2,
    REG_IMAGE_WIDTH   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [2:0][14:0]   color;
    logic [2:0][14:0]   albedo;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [1:0]         bank;
    logic [ENT_W-1:0]   entry;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } bk_status_t;

  typedef struct packed {
    logic [ENT_W-1:0]             addr;
    logic [NBANK-1:0][VAL_W-1:0]  acc;
    logic [NBANK-1:0][TERM_W-1:0] tn;
    logic [NBANK-1:0][TERM_W-1:0] tm;
  } sweep_t;

  // round half away from zero, then shift right
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                  input int unsigned s);
    logic signed [63:0] half;
    logic signed [63:0] mag;
    logic signed [63:0] r;
    half = 64'sd1 <<< (s - 1);
    mag  = v[63] ? -v : v;
    r    = (mag + half) >>> s;
    return v[63] ? -r : r;
  endfunction

  // vector terms pass unrounded, matrix terms round by 15; flip negates
  function automatic logic signed [TERM_W-1:0] round_term(
      input logic signed [TERM_W-1:0] v, input logic vec, input logic flip);
    logic              neg;
    logic [TERM_W-1:0] mag;
    logic [TERM_W-1:0] r;
    neg = v[TERM_W-1];
    mag = neg ? TERM_W'(-v) : TERM_W'(v);
    r   = vec ? mag : ((mag + TERM_W'(16384)) >> 15);
    return (neg ^ flip) ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_add(input logic signed [VAL_W-1:0] a,
                                                     input logic signed [TERM_W-1:0] t);
    logic signed [VAL_W-1:0] ext;
    logic signed [VAL_W-1:0] sum;
    ext = VAL_W'(t);
    sum = a + ext;
    if ((a[VAL_W-1] == ext[VAL_W-1]) && (sum[VAL_W-1] != a[VAL_W-1])) begin
      return a[VAL_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end
    return sum;
  endfunction

  // terms whose sign follows z in the mirrored basis
  function automatic logic mirror_neg(input logic [3:0] k);
    return (k == 4'd2) || (k == 4'd5) || (k == 4'd7);
  endfunction

endpackage

// File: hw/rtl/sh_lighting_normal_equation_accum.sv
// results: an item passes the command queue to the back end, which registers its
//   result; a read first passes a sum memory read in the read state
// back end use: a kept pixel holds the back end through issue, basis setup, a sweep
//   of the 90 memory entries at one read-modify-write per cycle and the drain of its
//   adds; a clear for a clearing pass, a read through the read state, others for issue
// reset: synchronous active low; then a pass over the 90 entries zeroes the sum memory
//   and input stays stalled; a clear item runs the same pass
module sh_lighting_normal_equation_accum
  import shlne_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_STEP  = MAX_STEP_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input items
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_op,
  input  logic [14:0]             in_color_r,
  input  logic [14:0]             in_color_g,
  input  logic [14:0]             in_color_b,
  input  logic [14:0]             in_albedo_r,
  input  logic [14:0]             in_albedo_g,
  input  logic [14:0]             in_albedo_b,
  input  logic                    in_albedo_valid,
  input  logic signed [15:0]      in_normal_x,
  input  logic signed [15:0]      in_normal_y,
  input  logic signed [15:0]      in_normal_z,
  input  logic [8:0]              in_read_index,
  // result items
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic                    out_bad_index,
  // register port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // config registers
  logic        per_channel_r;
  logic [14:0] mirror_weight_r;
  logic [4:0]  sample_step_r;
  logic [12:0] image_width_r;
  logic        cfg_wr;

  cmd_t       push_cmd, head_cmd;
  logic       q_push, q_full, q_pop, q_valid;
  bk_status_t bk_status;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      per_channel_r   <= RST_PER_CHANNEL;
      mirror_weight_r <= RST_MIRROR_WEIGHT;
      sample_step_r   <= RST_SAMPLE_STEP;
      image_width_r   <= RST_IMAGE_WIDTH;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_PER_CHANNEL:   per_channel_r   <= pwdata[0];
        REG_MIRROR_WEIGHT: mirror_weight_r <= pwdata[14:0];
        REG_SAMPLE_STEP:   sample_step_r   <= pwdata[4:0];
        REG_IMAGE_WIDTH:   image_width_r   <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_PER_CHANNEL:   prdata = {31'd0, per_channel_r};
      REG_MIRROR_WEIGHT: prdata = {17'd0, mirror_weight_r};
      REG_SAMPLE_STEP:   prdata = {27'd0, sample_step_r};
      REG_IMAGE_WIDTH:   prdata = {19'd0, image_width_r};
      default:           prdata = '0;
    endcase
  end

  // front end: raster position, keep test, read index decode
  shlne_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_STEP  (MAX_STEP)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_color_r      (in_color_r),
    .in_color_g      (in_color_g),
    .in_color_b      (in_color_b),
    .in_albedo_r     (in_albedo_r),
    .in_albedo_g     (in_albedo_g),
    .in_albedo_b     (in_albedo_b),
    .in_albedo_valid (in_albedo_valid),
    .in_normal_x     (in_normal_x),
    .in_normal_y     (in_normal_y),
    .in_normal_z     (in_normal_z),
    .in_read_index   (in_read_index),
    .sample_step     (sample_step_r),
    .image_width     (image_width_r),
    .bk_status       (bk_status),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (push_cmd)
  );

  // short command queue between the two halves
  shlne_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .cmd      (head_cmd)
  );

  // back end: basis setup, sweep over the three sum banks, reads and clears
  shlne_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .per_channel    (per_channel_r),
    .mirror_weight  (mirror_weight_r),
    .q_valid        (q_valid),
    .q_cmd          (head_cmd),
    .q_pop          (q_pop),
    .bk_status      (bk_status),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_bad_index  (out_bad_index)
  );

endmodule

// File: hw/rtl/shlne_ram.sv
module shlne_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 90
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/shlne_front.sv
module shlne_front
  import shlne_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_STEP  = MAX_STEP_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [14:0]        in_color_r,
  input  logic [14:0]        in_color_g,
  input  logic [14:0]        in_color_b,
  input  logic [14:0]        in_albedo_r,
  input  logic [14:0]        in_albedo_g,
  input  logic [14:0]        in_albedo_b,
  input  logic               in_albedo_valid,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic [8:0]         in_read_index,
  input  logic [4:0]         sample_step,
  input  logic [12:0]        image_width,
  input  bk_status_t         bk_status,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_cmd
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PW = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1;
  localparam int SW = $clog2(MAX_STEP + 1);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [CW-1:0] col_count_r, col_count_nxt;
  logic [PW-1:0] col_phase_r, col_phase_nxt;
  logic [PW-1:0] row_phase_r, row_phase_nxt;
  logic [SW-1:0] step_eff;
  logic [WW-1:0] width_eff;
  logic          accept;

  assign in_stall = q_full | bk_status.clearing;
  assign accept   = in_valid & ~in_stall;
  assign q_push   = accept;

  always_comb begin
    if (sample_step == 5'd0) begin
      step_eff = SW'(1);
    end else if (int'(sample_step) > MAX_STEP) begin
      step_eff = SW'(MAX_STEP);
    end else begin
      step_eff = SW'(sample_step);
    end
    if (image_width == 13'd0) begin
      width_eff = WW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(image_width);
    end
  end

  // classify and precompute the bank and entry of a read
  always_comb begin
    logic [8:0] m;
    m = in_read_index - 9'd27;
    q_cmd.color  = {in_color_b, in_color_g, in_color_r};
    q_cmd.albedo = {in_albedo_b, in_albedo_g, in_albedo_r};
    q_cmd.nx     = in_normal_x;
    q_cmd.ny     = in_normal_y;
    q_cmd.nz     = in_normal_z;
    q_cmd.bank   = 2'd0;
    q_cmd.entry  = '0;
    q_cmd.kind   = CMD_NOP;
    case (op_t'(in_op))
      OP_ACC: begin
        if (in_albedo_valid && col_phase_r == '0 && row_phase_r == '0) begin
          q_cmd.kind = CMD_ACC;
        end
      end
      OP_READ: begin
        if (in_read_index < 9'(NUM_VEC)) begin
          q_cmd.kind = CMD_READ;
          if (in_read_index >= 9'd18) begin
            q_cmd.bank  = 2'd2;
            q_cmd.entry = ENT_W'(in_read_index - 9'd18);
          end else if (in_read_index >= 9'd9) begin
            q_cmd.bank  = 2'd1;
            q_cmd.entry = ENT_W'(in_read_index - 9'd9);
          end else begin
            q_cmd.entry = ENT_W'(in_read_index);
          end
        end else if (in_read_index < 9'(NUM_SUMS)) begin
          q_cmd.kind = CMD_READ;
          if (m >= 9'd162) begin
            q_cmd.bank  = 2'd2;
            q_cmd.entry = ENT_W'(m - 9'd153);
          end else if (m >= 9'd81) begin
            q_cmd.bank  = 2'd1;
            q_cmd.entry = ENT_W'(m - 9'd72);
          end else begin
            q_cmd.entry = ENT_W'(m + 9'd9);
          end
        end else begin
          q_cmd.kind = CMD_BAD;
        end
      end
      OP_CLEAR: q_cmd.kind = CMD_CLEAR;
      default:  q_cmd.kind = CMD_NOP;
    endcase
  end

  always_comb begin
    col_count_nxt = col_count_r;
    col_phase_nxt = col_phase_r;
    row_phase_nxt = row_phase_r;
    if (accept && op_t'(in_op) == OP_ACC) begin
      col_phase_nxt = (int'(col_phase_r) + 1 >= int'(step_eff)) ? '0 : col_phase_r + 1'b1;
      if (int'(col_count_r) + 1 >= int'(width_eff)) begin
        col_count_nxt = '0;
        col_phase_nxt = '0;
        row_phase_nxt = (int'(row_phase_r) + 1 >= int'(step_eff)) ? '0 : row_phase_r + 1'b1;
      end else begin
        col_count_nxt = col_count_r + 1'b1;
      end
    end else if (accept && op_t'(in_op) == OP_CLEAR) begin
      col_count_nxt = '0;
      col_phase_nxt = '0;
      row_phase_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      col_phase_r <= '0;
      row_phase_r <= '0;
    end else begin
      col_count_r <= col_count_nxt;
      col_phase_r <= col_phase_nxt;
      row_phase_r <= row_phase_nxt;
    end
  end

endmodule

// File: hw/rtl/shlne_queue.sv
module shlne_queue
  import shlne_pkg::*;
#(
  parameter int DEPTH = QDEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t cmd
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  cmd_t            slot_r [DEPTH];
  logic [PTRW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTRW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;

  assign full  = (count_r == CNTW'(DEPTH));
  assign valid = (count_r != '0);
  assign cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: hw/rtl/shlne_back.sv
module shlne_back
  import shlne_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    per_channel,
  input  logic [14:0]             mirror_weight,
  input  logic                    q_valid,
  input  cmd_t                    q_cmd,
  output logic                    q_pop,
  output bk_status_t              bk_status,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic                    out_bad_index
);

  bk_state_t        state_r, state_nxt;
  logic [ENT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]       ri_r, ri_nxt, rj_r, rj_nxt;
  logic [1:0]       rd_bank_r;
  cmd_t             px_r;

  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic                    out_bad_r, out_bad_nxt;
  logic                    load_out, out_free, latch_px, latch_rd;

  // setup stage 1
  logic signed [32:0] kx_r, ky_r, kz_r;
  logic signed [31:0] nxny_r, nynz_r, nxnz_r, nznz_r, nxnx_r, nyny_r;
  logic [2:0][29:0]   colalb_r, albalb_r;
  // setup stage 2
  logic signed [16:0] b1_r, b2_r, b3_r;
  logic [2:0][14:0]   ca_r, aa_r;
  logic signed [47:0] m4_r, m5_r, m6_r, m7_r, m8_r;
  // setup stage 3
  logic signed [16:0] b4_r, b5_r, b6p_r, b7_r, b8_r;
  logic [2:0][29:0]   cawp_r, aawp_r;
  // setup stage 4
  logic signed [16:0] b6_r;
  logic [2:0][14:0]   caw_r, aaw_r;

  logic signed [16:0] basis [NTERM];
  logic signed [16:0] bi, bj;
  logic               vec_a;

  // sweep pipeline
  logic                     sa_v_r, sa_vec_r, sa_neg_r;
  logic [ENT_W-1:0]         sa_addr_r;
  logic signed [31:0]       sa_bb_r;
  logic                     sb_v_r, sb_vec_r, sb_neg_r;
  logic [ENT_W-1:0]         sb_addr_r;
  logic [2:0][TERM_W-1:0]   pn_r, pm_r;
  logic [2:0][VAL_W-1:0]    sb_data_r;
  sweep_t                   stg_r [NADD+1];
  sweep_t                   stg_nxt [NADD+1];
  logic [NADD:0]            sv_r;
  logic                     pipe_busy;

  logic [ENT_W-1:0]      ram_raddr, ram_waddr;
  logic                  ram_we;
  logic [VAL_W-1:0]      ram_wdata [NBANK];
  logic [VAL_W-1:0]      ram_rdata [NBANK];

  for (genvar g = 0; g < NBANK; g++) begin : g_bank
    shlne_ram #(
      .WIDTH (VAL_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata[g]),
      .raddr (ram_raddr),
      .rdata (ram_rdata[g])
    );
  end

  assign bk_status.clearing = (state_r == BK_CLEAR);
  assign pipe_busy = sa_v_r | sb_v_r | (|sv_r);
  assign out_free  = ~out_valid_r | ~out_stall;
  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_bad_index  = out_bad_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ri_nxt        = ri_r;
    rj_nxt        = rj_r;
    q_pop         = 1'b0;
    load_out      = 1'b0;
    latch_px      = 1'b0;
    latch_rd      = 1'b0;
    out_value_nxt = '0;
    out_bad_nxt   = 1'b0;
    case (state_r)
      BK_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ENT_W'(BANK_DEPTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid && !pipe_busy) begin
          case (q_cmd.kind)
            CMD_READ: begin
              if (!out_valid_r) begin
                q_pop     = 1'b1;
                latch_rd  = 1'b1;
                state_nxt = BK_READ;
              end
            end
            CMD_ACC: begin
              if (out_free) begin
                q_pop     = 1'b1;
                load_out  = 1'b1;
                latch_px  = 1'b1;
                cnt_nxt   = '0;
                state_nxt = BK_SETUP;
              end
            end
            CMD_CLEAR: begin
              if (out_free) begin
                q_pop     = 1'b1;
                load_out  = 1'b1;
                cnt_nxt   = '0;
                state_nxt = BK_CLEAR;
              end
            end
            CMD_BAD: begin
              if (out_free) begin
                q_pop       = 1'b1;
                load_out    = 1'b1;
                out_bad_nxt = 1'b1;
              end
            end
            default: begin
              if (out_free) begin
                q_pop    = 1'b1;
                load_out = 1'b1;
              end
            end
          endcase
        end
      end
      BK_SETUP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ENT_W'(SETUP_CYC - 1)) begin
          cnt_nxt   = '0;
          ri_nxt    = '0;
          rj_nxt    = '0;
          state_nxt = BK_SWEEP;
        end
      end
      BK_SWEEP: begin
        cnt_nxt = cnt_r + 1'b1;
        rj_nxt  = (rj_r == 4'(NTERM - 1)) ? '0 : rj_r + 1'b1;
        if (rj_r == 4'(NTERM - 1) && !vec_a) begin
          ri_nxt = ri_r + 1'b1;
        end
        if (cnt_r == ENT_W'(BANK_DEPTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = BK_IDLE;
        end
      end
      BK_READ: begin
        load_out  = 1'b1;
        state_nxt = BK_IDLE;
        case (rd_bank_r)
          2'd0:    out_value_nxt = ram_rdata[0];
          2'd1:    out_value_nxt = ram_rdata[1];
          2'd2:    out_value_nxt = ram_rdata[2];
          default: out_value_nxt = '0;
        endcase
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      cnt_r       <= '0;
      ri_r        <= '0;
      rj_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ri_r    <= ri_nxt;
      rj_r    <= rj_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value_r <= out_value_nxt;
      out_bad_r   <= out_bad_nxt;
    end
    if (latch_px) begin
      px_r <= q_cmd;
    end
    if (latch_rd) begin
      rd_bank_r <= q_cmd.bank;
    end
  end

  // basis and scale setup, four register stages
  always_ff @(posedge clk) begin
    kx_r   <= K_2C2 * px_r.nx;
    ky_r   <= K_2C2 * px_r.ny;
    kz_r   <= K_2C2 * px_r.nz;
    nxny_r <= px_r.nx * px_r.ny;
    nynz_r <= px_r.ny * px_r.nz;
    nxnz_r <= px_r.nx * px_r.nz;
    nznz_r <= px_r.nz * px_r.nz;
    nxnx_r <= px_r.nx * px_r.nx;
    nyny_r <= px_r.ny * px_r.ny;
    for (int c = 0; c < NBANK; c++) begin
      colalb_r[c] <= px_r.color[c] * px_r.albedo[c];
      albalb_r[c] <= px_r.albedo[c] * px_r.albedo[c];
    end

    b1_r <= 17'(rnd_shift(64'(ky_r), 15));
    b2_r <= 17'(rnd_shift(64'(kz_r), 15));
    b3_r <= 17'(rnd_shift(64'(kx_r), 15));
    for (int c = 0; c < NBANK; c++) begin
      ca_r[c] <= 15'(rnd_shift($signed(64'(colalb_r[c])), 15));
      aa_r[c] <= 15'(rnd_shift($signed(64'(albalb_r[c])), 15));
    end
    m4_r <= K_2C1 * nxny_r;
    m5_r <= K_2C1 * nynz_r;
    m7_r <= K_2C1 * nxnz_r;
    m6_r <= K_C3 * nznz_r;
    m8_r <= K_C1 * (nxnx_r - nyny_r);

    b4_r  <= 17'(rnd_shift(64'(m4_r), 30));
    b5_r  <= 17'(rnd_shift(64'(m5_r), 30));
    b6p_r <= 17'(rnd_shift(64'(m6_r), 30));
    b7_r  <= 17'(rnd_shift(64'(m7_r), 30));
    b8_r  <= 17'(rnd_shift(64'(m8_r), 30));
    for (int c = 0; c < NBANK; c++) begin
      cawp_r[c] <= ca_r[c] * mirror_weight;
      aawp_r[c] <= aa_r[c] * mirror_weight;
    end

    b6_r <= b6p_r - K_C5;
    for (int c = 0; c < NBANK; c++) begin
      caw_r[c] <= 15'(rnd_shift($signed(64'(cawp_r[c])), 15));
      aaw_r[c] <= 15'(rnd_shift($signed(64'(aawp_r[c])), 15));
    end
  end

  assign basis[0] = K_C4;
  assign basis[1] = b1_r;
  assign basis[2] = b2_r;
  assign basis[3] = b3_r;
  assign basis[4] = b4_r;
  assign basis[5] = b5_r;
  assign basis[6] = b6_r;
  assign basis[7] = b7_r;
  assign basis[8] = b8_r;

  // sweep stage a: basis product and mirror sign for the entry
  assign vec_a = (cnt_r < ENT_W'(NTERM));
  assign bi    = basis[vec_a ? rj_r : ri_r];
  assign bj    = basis[rj_r];

  assign ram_raddr = (state_r == BK_SWEEP) ? cnt_r : q_cmd.entry;

  always_ff @(posedge clk) begin
    sa_bb_r   <= vec_a ? 32'(bj) : bi * bj;
    sa_vec_r  <= vec_a;
    sa_neg_r  <= vec_a ? mirror_neg(rj_r) : (mirror_neg(ri_r) ^ mirror_neg(rj_r));
    sa_addr_r <= cnt_r;

    sb_vec_r  <= sa_vec_r;
    sb_neg_r  <= sa_neg_r;
    sb_addr_r <= sa_addr_r;
    for (int c = 0; c < NBANK; c++) begin
      pn_r[c]      <= $signed({1'b0, sa_vec_r ? ca_r[c] : aa_r[c]}) * sa_bb_r;
      pm_r[c]      <= $signed({1'b0, sa_vec_r ? caw_r[c] : aaw_r[c]}) * sa_bb_r;
      sb_data_r[c] <= ram_rdata[c];
    end

    for (int k = 0; k <= NADD; k++) begin
      stg_r[k] <= stg_nxt[k];
    end
  end

  // saturating adds; shared sums: normal r g b then mirrored r g b
  always_comb begin
    logic signed [TERM_W-1:0] t;
    stg_nxt[0].addr = sb_addr_r;
    for (int c = 0; c < NBANK; c++) begin
      stg_nxt[0].acc[c] = sb_data_r[c];
      stg_nxt[0].tn[c]  = round_term($signed(pn_r[c]), sb_vec_r, 1'b0);
      stg_nxt[0].tm[c]  = round_term($signed(pm_r[c]), sb_vec_r, sb_neg_r);
    end
    for (int k = 0; k < NADD; k++) begin
      stg_nxt[k+1] = stg_r[k];
      for (int c = 0; c < NBANK; c++) begin
        if (per_channel) begin
          t = (k == 0) ? $signed(stg_r[k].tn[c]) :
              (k == 1) ? $signed(stg_r[k].tm[c]) : '0;
        end else if (c == 0) begin
          t = (k < 3) ? $signed(stg_r[k].tn[k]) : $signed(stg_r[k].tm[k-3]);
        end else begin
          t = '0;
        end
        stg_nxt[k+1].acc[c] = sat_add($signed(stg_r[k].acc[c]), t);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r <= 1'b0;
      sb_v_r <= 1'b0;
      sv_r   <= '0;
    end else begin
      sa_v_r <= (state_r == BK_SWEEP);
      sb_v_r <= sa_v_r;
      sv_r   <= {sv_r[NADD-1:0], sb_v_r};
    end
  end

  // write back at the end of the adds, or zero during a clearing pass
  always_comb begin
    ram_we    = sv_r[NADD] | (state_r == BK_CLEAR);
    ram_waddr = (state_r == BK_CLEAR) ? cnt_r : stg_r[NADD].addr;
    for (int c = 0; c < NBANK; c++) begin
      ram_wdata[c] = (state_r == BK_CLEAR) ? '0 : stg_r[NADD].acc[c];
    end
  end

endmodule

// File: hw/rtl/shlne_checker.sv
module shlne_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_read_value,
  input logic        out_bad_index,
  input logic        pready
);

  // the clearing pass holds off input right after reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled during clearing pass");

  a_bad_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_index |-> out_read_value == 64'd0)
    else $error("bad index result carries a value");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value)
                               && $stable(out_bad_index))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("register port not ready");

endmodule

bind sh_lighting_normal_equation_accum shlne_checker u_shlne_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_read_value (out_read_value),
  .out_bad_index  (out_bad_index),
  .pready         (pready)
);

// File: tb/sv/testbench.sv
module testbench;
  import shlne_pkg::*;

  // one input item as the block sees it
  typedef struct {
    op_t         op;
    logic [14:0] color [3];
    logic [14:0] albedo [3];
    logic        albedo_valid;
    logic signed [15:0] nx, ny, nz;
    logic [8:0]  read_index;
  } pixel_item_t;

  // one expected result item
  typedef struct {
    longint value;
    bit     bad;
  } sum_read_t;

  localparam longint CYCLE_LIMIT = 2000000;
  localparam int     DRAIN_CYCLES = 160;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_op = '0;
  logic [14:0]        in_color_r = '0, in_color_g = '0, in_color_b = '0;
  logic [14:0]        in_albedo_r = '0, in_albedo_g = '0, in_albedo_b = '0;
  logic               in_albedo_valid = 1'b0;
  logic signed [15:0] in_normal_x = '0, in_normal_y = '0, in_normal_z = '0;
  logic [8:0]         in_read_index = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [63:0] out_read_value;
  logic               out_bad_index;

  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sh_lighting_normal_equation_accum dut (.*);

  // clock, period 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the block: sums, raster position, registers
  longint      vec_sum [27];
  longint      mat_sum [243];
  int unsigned col_count, col_phase, row_phase;
  int unsigned cfg_per_channel, cfg_mirror_weight, cfg_sample_step, cfg_image_width;

  sum_read_t pending_sums [$];
  int        mismatches = 0;
  longint    cycle_count = 0;
  bit        no_idle = 1'b0;   // when set, neither side idles

  // ---------------------------------------------------------------- fixed point
  function automatic longint round_shift(longint v, int s);
    longint half;
    half = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic longint sat_sum(longint a, longint t);
    longint s;
    s = a + t;
    if (t > 0 && s < a) return 64'h7fff_ffff_ffff_ffff;
    if (t < 0 && s > a) return 64'h8000_0000_0000_0000;
    return s;
  endfunction

  // nine-term sh basis; the mirror flips the z-odd terms
  function automatic void sh_basis(longint nx, longint ny, longint nz, bit mirror,
                                   output longint b [9]);
    longint sg;
    sg = mirror ? -1 : 1;
    b[0] = 29040;
    b[1] = round_shift(33532 * ny, 15);
    b[2] = sg * round_shift(33532 * nz, 15);
    b[3] = round_shift(33532 * nx, 15);
    b[4] = round_shift(28118 * nx * ny, 30);
    b[5] = sg * round_shift(28118 * ny * nz, 30);
    b[6] = round_shift(24351 * nz * nz, 30) - 8117;
    b[7] = sg * round_shift(28118 * nx * nz, 30);
    b[8] = round_shift(14059 * (nx * nx - ny * ny), 30);
  endfunction

  function automatic void add_normal_terms(int blk, longint ca, longint aa, longint b [9]);
    int k;
    for (int i = 0; i < 9; i++)
      vec_sum[blk * 9 + i] = sat_sum(vec_sum[blk * 9 + i], ca * b[i]);
    for (int i = 0; i < 9; i++)
      for (int j = 0; j < 9; j++) begin
        k = blk * 81 + i * 9 + j;
        mat_sum[k] = sat_sum(mat_sum[k], round_shift(aa * b[i] * b[j], 15));
      end
  endfunction

  function automatic void clear_sums();
    foreach (vec_sum[i]) vec_sum[i] = 0;
    foreach (mat_sum[i]) mat_sum[i] = 0;
    col_count = 0;
    col_phase = 0;
    row_phase = 0;
  endfunction

  // raster tracking with clamped step and width
  function automatic void step_raster();
    int unsigned stp, wid;
    stp = (cfg_sample_step == 0) ? 1 : (cfg_sample_step > 16 ? 16 : cfg_sample_step);
    wid = (cfg_image_width == 0) ? 1 : (cfg_image_width > 4096 ? 4096 : cfg_image_width);
    col_phase = (col_phase + 1 >= stp) ? 0 : col_phase + 1;
    if (col_count + 1 >= wid) begin
      col_count = 0;
      col_phase = 0;
      row_phase = (row_phase + 1 >= stp) ? 0 : row_phase + 1;
    end else begin
      col_count++;
    end
  endfunction

  // expected result of one accepted item, updating the shadow sums
  function automatic sum_read_t predict_sums(pixel_item_t it);
    sum_read_t r;
    longint b [9], bm [9], ca [3], aa [3];
    r.value = 0;
    r.bad = 1'b0;
    case (it.op)
      OP_ACC: begin
        if (it.albedo_valid && col_phase == 0 && row_phase == 0) begin
          sh_basis(it.nx, it.ny, it.nz, 1'b0, b);
          sh_basis(it.nx, it.ny, it.nz, 1'b1, bm);
          for (int c = 0; c < 3; c++) begin
            ca[c] = round_shift(longint'(it.color[c]) * longint'(it.albedo[c]), 15);
            aa[c] = round_shift(longint'(it.albedo[c]) * longint'(it.albedo[c]), 15);
          end
          for (int c = 0; c < 3; c++)
            add_normal_terms(cfg_per_channel ? c : 0, ca[c], aa[c], b);
          for (int c = 0; c < 3; c++)
            add_normal_terms(cfg_per_channel ? c : 0,
                             round_shift(ca[c] * cfg_mirror_weight, 15),
                             round_shift(aa[c] * cfg_mirror_weight, 15), bm);
        end
        step_raster();
      end
      OP_READ: begin
        if (it.read_index < 27) r.value = vec_sum[it.read_index];
        else if (it.read_index < 270) r.value = mat_sum[it.read_index - 27];
        else r.bad = 1'b1;
      end
      OP_CLEAR: clear_sums();
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- item builders
  function automatic pixel_item_t blank_item(op_t op);
    pixel_item_t it;
    it.op = op;
    for (int c = 0; c < 3; c++) begin
      it.color[c] = 15'($urandom);
      it.albedo[c] = 15'($urandom);
    end
    it.albedo_valid = 1'($urandom);
    it.nx = 16'($urandom);
    it.ny = 16'($urandom);
    it.nz = 16'($urandom);
    it.read_index = 9'($urandom);
    return it;
  endfunction

  function automatic logic [14:0] rand_q15();
    case ($urandom_range(9))
      0: return 15'd0;
      1: return 15'h7fff;
      default: return 15'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_normal();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pixel_item_t pixel(bit valid_albedo);
    pixel_item_t it;
    it = blank_item(OP_ACC);
    for (int c = 0; c < 3; c++) begin
      it.color[c] = rand_q15();
      it.albedo[c] = rand_q15();
    end
    it.albedo_valid = valid_albedo;
    it.nx = rand_normal();
    it.ny = rand_normal();
    it.nz = rand_normal();
    return it;
  endfunction

  function automatic pixel_item_t read_item(int idx);
    pixel_item_t it;
    it = blank_item(OP_READ);
    it.read_index = 9'(idx);
    return it;
  endfunction

  // ---------------------------------------------------------------- drivers
  // caller stands at a rising edge; returns after the item is taken and any idles
  task automatic send_item(pixel_item_t it);
    in_op <= it.op;
    in_color_r <= it.color[0];
    in_color_g <= it.color[1];
    in_color_b <= it.color[2];
    in_albedo_r <= it.albedo[0];
    in_albedo_g <= it.albedo[1];
    in_albedo_b <= it.albedo[2];
    in_albedo_valid <= it.albedo_valid;
    in_normal_x <= it.nx;
    in_normal_y <= it.ny;
    in_normal_z <= it.nz;
    in_read_index <= it.read_index;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_sums.push_back(predict_sums(it));
    // random idle cycles after the item
    if (!no_idle) begin
      while ($urandom_range(99) < 21) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // wait until every expected result is back, then let the back end settle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(4 * idx);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PER_CHANNEL:   cfg_per_channel = value & 1;
      REG_MIRROR_WEIGHT: cfg_mirror_weight = value & 32'h7fff;
      REG_SAMPLE_STEP:   cfg_sample_step = value & 32'h1f;
      REG_IMAGE_WIDTH:   cfg_image_width = value & 32'h1fff;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_raster(int unsigned width, int unsigned stp);
    write_reg(REG_IMAGE_WIDTH, width);
    write_reg(REG_SAMPLE_STEP, stp);
  endtask

  // ---------------------------------------------------------------- result side
  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  // receiver stall, about a fifth of the cycles unless idling is off
  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < 21);
  end

  always @(posedge clk) begin
    sum_read_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sums.size() == 0) begin
        report_mismatch("unexpected result item", out_read_value, 0);
      end else begin
        want = pending_sums.pop_front();
        if (out_read_value !== want.value)
          report_mismatch("read_value", out_read_value, want.value);
        if (out_bad_index !== want.bad)
          report_mismatch("bad_index", out_bad_index, want.bad);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL sh_lighting_normal_equation_accum");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  // reads on empty sums, index edges, unknown op, extreme pixels, more reads, a clear
  task automatic test_edges_and_extremes();
    pixel_item_t it;
    int idx_list [6] = '{0, 26, 27, 269, 270, 511};
    foreach (idx_list[i]) send_item(read_item(idx_list[i]));
    send_item(blank_item(OP_NONE));
    // all-ones colour and albedo with extreme normals, then albedo mask off once
    it = pixel(1'b1);
    for (int c = 0; c < 3; c++) begin
      it.color[c] = 15'h7fff;
      it.albedo[c] = 15'h7fff;
    end
    it.nx = 16'sh7fff;
    it.ny = 16'sh8000;
    it.nz = 16'sh8000;
    send_item(it);
    it.nx = 16'sh8000;
    it.ny = 16'sh7fff;
    it.nz = 16'sh7fff;
    send_item(it);
    it = pixel(1'b0);
    send_item(it);
    send_item(pixel(1'b1));
    foreach (idx_list[i]) send_item(read_item(idx_list[i]));
    send_item(read_item(27 + 81 + 40));
    send_item(blank_item(OP_CLEAR));
    send_item(read_item(0));
    send_item(read_item(27));
    drain_results();
  endtask

  // subsampling across rows and columns on a tiny raster, shared sums
  task automatic test_subsampling();
    write_reg(REG_PER_CHANNEL, 0);
    write_reg(REG_MIRROR_WEIGHT, 32767);
    set_raster(5, 2);
    for (int i = 0; i < 20; i++) send_item(pixel(1'b1));
    for (int i = 0; i < 27; i++) send_item(read_item(i * 10));
    drain_results();
  endtask

  // random traffic under a given setting
  task automatic random_phase(int items, bit clear_first);
    pixel_item_t it;
    int pick;
    if (clear_first) send_item(blank_item(OP_CLEAR));
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (pick < 65) it = pixel($urandom_range(9) != 0);
      else if (pick < 88) it = read_item($urandom_range(pick < 80 ? 269 : 511));
      else if (pick < 92) it = blank_item(OP_CLEAR);
      else if (pick < 96) it = blank_item(OP_NONE);
      else it = blank_item(OP_ACC);   // broken pixel with random content
      send_item(it);
    end
  endtask

  task automatic test_random_settings();
    // defaults restored, odd raster
    write_reg(REG_PER_CHANNEL, 1);
    write_reg(REG_MIRROR_WEIGHT, 6554);
    set_raster(7, 1);
    random_phase(50, 1'b0);
    drain_results();

    // step clamps above its limit, width below one
    write_reg(REG_MIRROR_WEIGHT, 0);
    set_raster(0, 31);
    random_phase(40, 1'b1);
    drain_results();

    // zero step acts as one, width clamps high; no idling on either side
    no_idle = 1'b1;
    write_reg(REG_PER_CHANNEL, 0);
    write_reg(REG_MIRROR_WEIGHT, $urandom_range(32767));
    set_raster(8191, 0);
    random_phase(50, 1'b1);
    drain_results();
    no_idle = 1'b0;

    // step sixteen on a small raster so the kept grid is sparse
    write_reg(REG_PER_CHANNEL, 1);
    set_raster(4, 16);
    for (int i = 0; i < 150; i++) send_item(pixel(1'b1));
    for (int i = 0; i < 20; i++) send_item(read_item($urandom_range(269)));
    drain_results();

    // random settings, mixed traffic
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(REG_PER_CHANNEL, $urandom_range(1));
      write_reg(REG_MIRROR_WEIGHT, $urandom_range(32767));
      set_raster($urandom_range(1, 12), $urandom_range(1, 4));
      random_phase(40, ph == 0);
      drain_results();
    end
  endtask

  initial begin
    clear_sums();
    cfg_per_channel = 1;
    cfg_mirror_weight = 6554;
    cfg_sample_step = 1;
    cfg_image_width = 640;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edges_and_extremes();
    test_subsampling();
    test_random_settings();

    drain_results();
    if (mismatches == 0) begin
      $display("PASS sh_lighting_normal_equation_accum");
    end else begin
      $display("FAIL sh_lighting_normal_equation_accum");
    end
    $finish;
  end

endmodule
